### rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, codes, pipeline word types and the divider step for the
// pixel color converter.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int PIX_W  = 8;    // channel and result width
   localparam int PROD_W = 24;   // gray weighted products and their sum
   localparam int HRAW_W = 18;   // signed hue numerator before wrap
   localparam int REM_W  = 17;   // divider remainder and shifted divisor
   localparam int QUO_W  = 8;    // quotient bits, one per divider step
   localparam int DIV_STAGES = 4;
   localparam int STEPS_PER_STAGE = QUO_W / DIV_STAGES;

   // Q16 gray weights, summing to 65536
   localparam logic [15:0] WEIGHT_B = 16'd7209;
   localparam logic [15:0] WEIGHT_G = 16'd38666;
   localparam logic [15:0] WEIGHT_R = 16'd19661;

   localparam logic MODE_GRAY = 1'b0;
   localparam logic MODE_HSV  = 1'b1;

   // which channel holds the maximum
   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   typedef struct packed {
      logic                mode;
      logic [PIX_W-1:0]    blue;
      logic [PIX_W-1:0]    green;
      logic [PIX_W-1:0]    red;
      logic [PIX_W-1:0]    value;
      logic [PIX_W-1:0]    low;
      logic [1:0]          sel;
      logic [PROD_W-1:0]   prod_b;
      logic [PROD_W-1:0]   prod_g;
      logic [PROD_W-1:0]   prod_r;
   } s1_type;

   typedef struct packed {
      logic                mode;
      logic [PIX_W-1:0]    gray;
      logic [PIX_W-1:0]    value;
      logic [PIX_W-1:0]    delta;
      logic [REM_W-1:0]    sat_num;
      logic [HRAW_W-1:0]   hue_raw;
   } s2_type;

   typedef struct packed {
      logic [REM_W-1:0]    rem;
      logic [REM_W-1:0]    dsh;
      logic [QUO_W-1:0]    quo;
      logic                ok;
   } lane_type;

   typedef struct packed {
      logic                mode;
      logic [PIX_W-1:0]    gray;
      logic [PIX_W-1:0]    value;
      lane_type            sat;
      lane_type            hue;
   } div_type;

   // one restoring step: produce one quotient bit, halve the divisor
   function automatic lane_type div_step(input lane_type x);
      lane_type y;
      y = x;
      if (x.rem >= x.dsh) begin
         y.rem = x.rem - x.dsh;
         y.quo = {x.quo[QUO_W-2:0], 1'b1};
      end else begin
         y.quo = {x.quo[QUO_W-2:0], 1'b0};
      end
      y.dsh = {1'b0, x.dsh[REM_W-1:1]};
      return y;
   endfunction

endpackage

### rtl/core/pcc_req_if.sv
// ----------------------------------------------------------------------------
// pcc_req_if
// Pixel input channel: valid/ready handshake with blue, green, red payload.
// ----------------------------------------------------------------------------
interface pcc_req_if;
   logic                      valid;
   logic                      ready;
   logic [pcc_pkg::PIX_W-1:0] blue;
   logic [pcc_pkg::PIX_W-1:0] green;
   logic [pcc_pkg::PIX_W-1:0] red;

   modport source (output valid, output blue, output green, output red, input ready);
   modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

### rtl/core/pcc_rsp_if.sv
// ----------------------------------------------------------------------------
// pcc_rsp_if
// Result channel: valid/ready handshake with gray/value, saturation, hue.
// ----------------------------------------------------------------------------
interface pcc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [pcc_pkg::PIX_W-1:0] gray_or_value;
   logic [pcc_pkg::PIX_W-1:0] saturation;
   logic [pcc_pkg::PIX_W-1:0] hue_half;

   modport source (output valid, output gray_or_value, output saturation,
                   output hue_half, input ready);
   modport sink   (input valid, input gray_or_value, input saturation,
                   input hue_half, output ready);
endinterface

### rtl/core/pcc_front.sv
// ----------------------------------------------------------------------------
// pcc_front
// Three pipeline stages: max/min and gray products, delta and numerators,
// hue wrap and divider setup.
// ----------------------------------------------------------------------------
module pcc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mode,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [pcc_pkg::PIX_W-1:0] in_blue,
   input  logic [pcc_pkg::PIX_W-1:0] in_green,
   input  logic [pcc_pkg::PIX_W-1:0] in_red,
   output logic                      out_valid,
   input  logic                      out_ready,
   output pcc_pkg::div_type          out_data
);

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   pcc_pkg::s1_type  s1_in, s1_ff;
   pcc_pkg::s2_type  s2_in, s2_ff;
   pcc_pkg::div_type s3_in, s3_ff;

   logic [pcc_pkg::HRAW_W-1:0] hue_diff;
   logic [pcc_pkg::HRAW_W-1:0] hue_base;
   logic [pcc_pkg::HRAW_W-1:0] hue_wrap;
   logic [15:0]                hue_h2;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: channel max/min and weighted products
   always_comb begin
      s1_in.mode   = mode;
      s1_in.blue   = in_blue;
      s1_in.green  = in_green;
      s1_in.red    = in_red;
      s1_in.prod_b = pcc_pkg::PROD_W'(pcc_pkg::WEIGHT_B) * pcc_pkg::PROD_W'(in_blue);
      s1_in.prod_g = pcc_pkg::PROD_W'(pcc_pkg::WEIGHT_G) * pcc_pkg::PROD_W'(in_green);
      s1_in.prod_r = pcc_pkg::PROD_W'(pcc_pkg::WEIGHT_R) * pcc_pkg::PROD_W'(in_red);
      // red wins ties, then green
      if (in_red >= in_green && in_red >= in_blue) begin
         s1_in.sel   = pcc_pkg::SEL_RED;
         s1_in.value = in_red;
      end else if (in_green >= in_blue) begin
         s1_in.sel   = pcc_pkg::SEL_GREEN;
         s1_in.value = in_green;
      end else begin
         s1_in.sel   = pcc_pkg::SEL_BLUE;
         s1_in.value = in_blue;
      end
      if (in_red <= in_green && in_red <= in_blue) begin
         s1_in.low = in_red;
      end else if (in_green <= in_blue) begin
         s1_in.low = in_green;
      end else begin
         s1_in.low = in_blue;
      end
   end

   // stage 2: delta, gray level, saturation numerator, hue numerator times delta
   always_comb begin
      s2_in.mode  = s1_ff.mode;
      s2_in.value = s1_ff.value;
      s2_in.delta = s1_ff.value - s1_ff.low;
      s2_in.gray  = 8'((s1_ff.prod_b + s1_ff.prod_g + s1_ff.prod_r) >> 16);
      s2_in.sat_num = pcc_pkg::REM_W'(510) * pcc_pkg::REM_W'(s2_in.delta)
                    + pcc_pkg::REM_W'(s1_ff.value);
      // modular arithmetic, bit 17 is the sign
      case (s1_ff.sel)
         pcc_pkg::SEL_RED: begin
            hue_diff = pcc_pkg::HRAW_W'(s1_ff.green) - pcc_pkg::HRAW_W'(s1_ff.blue);
            hue_base = '0;
         end
         pcc_pkg::SEL_GREEN: begin
            hue_diff = pcc_pkg::HRAW_W'(s1_ff.blue) - pcc_pkg::HRAW_W'(s1_ff.red);
            hue_base = pcc_pkg::HRAW_W'(60) * pcc_pkg::HRAW_W'(s2_in.delta);
         end
         default: begin
            hue_diff = pcc_pkg::HRAW_W'(s1_ff.red) - pcc_pkg::HRAW_W'(s1_ff.green);
            hue_base = pcc_pkg::HRAW_W'(120) * pcc_pkg::HRAW_W'(s2_in.delta);
         end
      endcase
      s2_in.hue_raw = hue_base + pcc_pkg::HRAW_W'(30) * hue_diff;
   end

   // stage 3: wrap negative hue, set up both dividers
   always_comb begin
      if (s2_ff.hue_raw[pcc_pkg::HRAW_W-1]) begin
         hue_wrap = s2_ff.hue_raw
                  + pcc_pkg::HRAW_W'(180) * pcc_pkg::HRAW_W'(s2_ff.delta);
      end else begin
         hue_wrap = s2_ff.hue_raw;
      end
      hue_h2 = hue_wrap[15:0];

      s3_in.mode  = s2_ff.mode;
      s3_in.gray  = s2_ff.gray;
      s3_in.value = s2_ff.value;

      s3_in.sat.rem = s2_ff.sat_num;
      s3_in.sat.dsh = pcc_pkg::REM_W'({s2_ff.value, 1'b0}) << (pcc_pkg::QUO_W - 1);
      s3_in.sat.quo = '0;
      s3_in.sat.ok  = (s2_ff.value != '0);

      s3_in.hue.rem = pcc_pkg::REM_W'({hue_h2, 1'b0}) + pcc_pkg::REM_W'(s2_ff.delta);
      s3_in.hue.dsh = pcc_pkg::REM_W'({s2_ff.delta, 1'b0}) << (pcc_pkg::QUO_W - 1);
      s3_in.hue.quo = '0;
      s3_in.hue.ok  = (s2_ff.delta != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) s1_ff <= s1_in;
      if (en2 && v1_ff) s2_ff <= s2_in;
      if (en3 && v2_ff) s3_ff <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

### rtl/core/pcc_div_stage.sv
// ----------------------------------------------------------------------------
// pcc_div_stage
// One divider pipeline stage: STEPS_PER_STAGE restoring steps on the saturation and
// hue quotients side by side.
// ----------------------------------------------------------------------------
module pcc_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pcc_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output pcc_pkg::div_type out_data
);

   logic             valid_ff;
   logic             en;
   pcc_pkg::div_type data_in, data_ff;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < pcc_pkg::STEPS_PER_STAGE; i++) begin
         data_in.sat = pcc_pkg::div_step(data_in.sat);
         data_in.hue = pcc_pkg::div_step(data_in.hue);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/core/pixel_color_converter.sv
// ----------------------------------------------------------------------------
// pixel_color_converter
// Converts a blue/green/red pixel to a gray level or to HSV, set by the mode
// register (0 gray, 1 HSV).
//
// Takes one pixel per clock unless backpressure holds the pipeline, and gives
// one result per pixel, in order. A pixel passes through seven register
// stages: three front stages (max/min and gray products, delta and numerators,
// hue wrap) followed by four divider stages that each resolve two quotient
// bits of the saturation and hue divisions. Backpressure stalls only the
// stages that hold data, so empty stages keep filling while a result waits.
// The mode is sampled with each pixel and should be written while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module pixel_color_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   pcc_req_if.sink     req_chan,
   pcc_rsp_if.source   rsp_chan
);

   logic mode_ff;

   logic             stg_valid [pcc_pkg::DIV_STAGES+1];
   logic             stg_ready [pcc_pkg::DIV_STAGES+1];
   pcc_pkg::div_type stg_data  [pcc_pkg::DIV_STAGES+1];

   pcc_pkg::div_type last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pcc_pkg::MODE_GRAY;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   pcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_blue   (req_chan.blue),
      .in_green  (req_chan.green),
      .in_red    (req_chan.red),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   for (genvar k = 0; k < pcc_pkg::DIV_STAGES; k++) begin : g_div
      pcc_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_data   (stg_data[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_data  (stg_data[k+1])
      );
   end

   assign last = stg_data[pcc_pkg::DIV_STAGES];

   assign stg_ready[pcc_pkg::DIV_STAGES] = rsp_chan.ready;
   assign rsp_chan.valid = stg_valid[pcc_pkg::DIV_STAGES];

   always_comb begin
      if (last.mode == pcc_pkg::MODE_HSV) begin
         rsp_chan.gray_or_value = last.value;
         rsp_chan.saturation    = last.sat.ok ? last.sat.quo : '0;
         rsp_chan.hue_half      = last.hue.ok ? last.hue.quo : '0;
      end else begin
         rsp_chan.gray_or_value = last.gray;
         rsp_chan.saturation    = '0;
         rsp_chan.hue_half      = '0;
      end
   end

endmodule
